// ===== hdl/fics_pkg.sv =====
package fics_pkg;

   localparam int NEEDLE_MAX = 64;
   localparam int NEEDLE_AW  = $clog2(NEEDLE_MAX);
   localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);
   localparam int POS_W      = 16;
   localparam int BYTE_W     = 8;

   localparam logic [POS_W-1:0]  TOKEN_MAX  = 16'hFFFF;
   localparam logic [BYTE_W-1:0] COMMA_BYTE = 8'h2C;
   localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

   localparam logic OP_NEEDLE = 1'b0;
   localparam logic OP_SET    = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [BYTE_W-1:0] char_byte;
      logic              last;
      logic              is_null;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             null_result;
      logic             needle_overflow;
   } result_type;

endpackage

// ===== hdl/find_in_comma_set_unit.sv =====
// channel | dir | tdata                | tuser                               | tlast
// req     | in  | [7:0] char_byte      | [0] operation, [1] is_null          | last
// rsp     | out | [15:0] position      | [0] null_result, [1] needle_overflow| -
//
// One byte per cycle but for the stall below: input register -> scan -> result register,
// which loads the result as the set string's last byte leaves the input register.
// The needle RAM is read ahead at the next match offset, with write forwarding.
// reset is synchronous and clears the row state; needle RAM contents are left as they are.
// A full result register stalls only a byte that closes a row; only then is req_tready low.
module find_in_comma_set_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic [1:0]  req_tuser,   // [0] operation, [1] is_null
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] position
   output logic [1:0]  rsp_tuser    // [0] null_result, [1] needle_overflow
);

   logic                 in_valid_ff, in_valid_in;
   fics_pkg::item_type   in_item_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   fics_pkg::result_type rsp_data_ff;
   fics_pkg::result_type scan_result;
   logic                 gives_result;
   logic                 out_free;
   logic                 advance;

   assign gives_result = (in_item_ff.operation == fics_pkg::OP_SET) && in_item_ff.last;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign advance      = in_valid_ff && (!gives_result || out_free);
   assign req_tready   = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && gives_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   fics_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (scan_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.operation <= req_tuser[0];
         in_item_ff.char_byte <= req_tdata;
         in_item_ff.last      <= req_tlast;
         in_item_ff.is_null   <= req_tuser[1];
      end
      if (advance && gives_result) begin
         rsp_data_ff <= scan_result;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff.position;
   assign rsp_tuser[0] = rsp_data_ff.null_result;
   assign rsp_tuser[1] = rsp_data_ff.needle_overflow;

endmodule

// ===== hdl/fics_ram.sv =====
module fics_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fics_scan.sv =====
module fics_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  fics_pkg::item_type  item,
   output fics_pkg::result_type result
);

   logic [fics_pkg::LEN_W-1:0]  needle_length_ff, needle_length_in;
   logic                        needle_has_comma_ff, needle_has_comma_in;
   logic                        needle_truncated_ff, needle_truncated_in;
   logic                        set_truncated_ff, set_truncated_in;
   logic                        saw_null_ff, saw_null_in;
   logic                        overflow_seen_ff, overflow_seen_in;
   logic [fics_pkg::POS_W-1:0]  token_count_ff, token_count_in;
   logic [fics_pkg::LEN_W-1:0]  match_offset_ff, match_offset_in;
   logic                        still_matching_ff, still_matching_in;
   logic                        token_nonempty_ff, token_nonempty_in;
   logic [fics_pkg::POS_W-1:0]  found_index_ff, found_index_in;

   logic                          fwd_valid_ff, fwd_valid_in;
   logic [fics_pkg::BYTE_W-1:0]   fwd_data_ff;

   logic                          wr_en;
   logic [fics_pkg::NEEDLE_AW-1:0] wr_addr;
   logic [fics_pkg::NEEDLE_AW-1:0] rd_addr;
   logic [fics_pkg::BYTE_W-1:0]   rd_data;
   logic [fics_pkg::BYTE_W-1:0]   needle_q;

   logic                          set_op;
   logic                          row_done;
   logic                          byte_active;
   logic                          data_byte;
   logic                          tok_close;
   logic                          nonempty_u;
   logic                          still_u;
   logic [fics_pkg::LEN_W-1:0]    offset_u;
   logic [fics_pkg::POS_W-1:0]    count_u;
   logic [fics_pkg::POS_W-1:0]    found_u;
   logic                          saw_null_u;

   assign needle_q = fwd_valid_ff ? fwd_data_ff : rd_data;
   assign set_op   = (item.operation == fics_pkg::OP_SET);
   assign row_done = advance && set_op && item.last;

   // needle append
   assign wr_en   = advance && !set_op && !item.is_null && !needle_truncated_ff
                    && (item.char_byte != fics_pkg::NUL_BYTE)
                    && (needle_length_ff < fics_pkg::LEN_W'(fics_pkg::NEEDLE_MAX));
   assign wr_addr = needle_length_ff[fics_pkg::NEEDLE_AW-1:0];

   // set byte scan
   always_comb begin
      byte_active = !item.is_null && !set_truncated_ff;
      data_byte   = byte_active && (item.char_byte != fics_pkg::NUL_BYTE)
                    && (item.char_byte != fics_pkg::COMMA_BYTE);
      tok_close   = item.last || (byte_active && ((item.char_byte == fics_pkg::NUL_BYTE)
                    || (item.char_byte == fics_pkg::COMMA_BYTE)));
      nonempty_u  = token_nonempty_ff || data_byte;
      still_u     = still_matching_ff;
      offset_u    = match_offset_ff;
      if (data_byte && still_matching_ff) begin
         if ((match_offset_ff < needle_length_ff) && (needle_q == item.char_byte)) begin
            offset_u = match_offset_ff + fics_pkg::LEN_W'(1);
         end else begin
            still_u = 1'b0;
         end
      end
      count_u = token_count_ff;
      found_u = found_index_ff;
      if (tok_close && nonempty_u) begin
         if (token_count_ff != fics_pkg::TOKEN_MAX) begin
            count_u = token_count_ff + fics_pkg::POS_W'(1);
         end
         if (still_u && (offset_u == needle_length_ff)
             && (found_index_ff == fics_pkg::POS_W'(0))) begin
            found_u = count_u;
         end
      end
      saw_null_u = saw_null_ff || item.is_null;
   end

   always_comb begin
      needle_length_in    = needle_length_ff;
      needle_has_comma_in = needle_has_comma_ff;
      needle_truncated_in = needle_truncated_ff;
      set_truncated_in    = set_truncated_ff;
      saw_null_in         = saw_null_ff;
      overflow_seen_in    = overflow_seen_ff;
      token_count_in      = token_count_ff;
      match_offset_in     = match_offset_ff;
      still_matching_in   = still_matching_ff;
      token_nonempty_in   = token_nonempty_ff;
      found_index_in      = found_index_ff;
      if (advance) begin
         saw_null_in = saw_null_u;
         if (!set_op) begin
            if (!item.is_null && !needle_truncated_ff) begin
               if (item.char_byte == fics_pkg::NUL_BYTE) begin
                  needle_truncated_in = 1'b1;
               end else begin
                  if (item.char_byte == fics_pkg::COMMA_BYTE) begin
                     needle_has_comma_in = 1'b1;
                  end
                  if (wr_en) begin
                     needle_length_in = needle_length_ff + fics_pkg::LEN_W'(1);
                  end else begin
                     overflow_seen_in = 1'b1;
                  end
               end
            end
         end else if (item.last) begin
            needle_length_in    = '0;
            needle_has_comma_in = 1'b0;
            needle_truncated_in = 1'b0;
            set_truncated_in    = 1'b0;
            saw_null_in         = 1'b0;
            overflow_seen_in    = 1'b0;
            token_count_in      = '0;
            found_index_in      = '0;
            match_offset_in     = '0;
            still_matching_in   = 1'b1;
            token_nonempty_in   = 1'b0;
         end else begin
            if (byte_active && (item.char_byte == fics_pkg::NUL_BYTE)) begin
               set_truncated_in = 1'b1;
            end
            token_count_in = count_u;
            found_index_in = found_u;
            if (tok_close) begin
               match_offset_in   = '0;
               still_matching_in = 1'b1;
               token_nonempty_in = 1'b0;
            end else begin
               match_offset_in   = offset_u;
               still_matching_in = still_u;
               token_nonempty_in = nonempty_u;
            end
         end
      end
   end

   // read ahead at the next offset; a write to that entry is forwarded
   assign rd_addr      = match_offset_in[fics_pkg::NEEDLE_AW-1:0];
   assign fwd_valid_in = wr_en && (wr_addr == rd_addr);

   always_comb begin
      result = '0;
      if (saw_null_u) begin
         result.null_result = 1'b1;
      end else begin
         result.needle_overflow = overflow_seen_ff;
         if (!needle_has_comma_ff && !overflow_seen_ff) begin
            result.position = found_u;
         end
      end
   end

   fics_ram #(
      .WIDTH (fics_pkg::BYTE_W),
      .DEPTH (fics_pkg::NEEDLE_MAX)
   ) u_needle_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item.char_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_length_ff    <= '0;
         needle_has_comma_ff <= 1'b0;
         needle_truncated_ff <= 1'b0;
         set_truncated_ff    <= 1'b0;
         saw_null_ff         <= 1'b0;
         overflow_seen_ff    <= 1'b0;
         token_count_ff      <= '0;
         match_offset_ff     <= '0;
         still_matching_ff   <= 1'b1;
         token_nonempty_ff   <= 1'b0;
         found_index_ff      <= '0;
         fwd_valid_ff        <= 1'b0;
      end else begin
         needle_length_ff    <= needle_length_in;
         needle_has_comma_ff <= needle_has_comma_in;
         needle_truncated_ff <= needle_truncated_in;
         set_truncated_ff    <= set_truncated_in;
         saw_null_ff         <= saw_null_in;
         overflow_seen_ff    <= overflow_seen_in;
         token_count_ff      <= token_count_in;
         match_offset_ff     <= match_offset_in;
         still_matching_ff   <= still_matching_in;
         token_nonempty_ff   <= token_nonempty_in;
         found_index_ff      <= found_index_in;
         fwd_valid_ff        <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= item.char_byte;
   end

   a_offset_in_needle: assert property (@(posedge clock) disable iff (reset)
      match_offset_ff <= needle_length_ff)
      else $error("match offset beyond needle length");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      needle_length_ff <= fics_pkg::LEN_W'(fics_pkg::NEEDLE_MAX))
      else $error("needle length beyond store");

   a_row_cleared: assert property (@(posedge clock) disable iff (reset)
      row_done |=> (needle_length_ff == '0) && (token_count_ff == '0)
                   && (found_index_ff == '0) && !saw_null_ff)
      else $error("row state not cleared after result");

   a_found_counted: assert property (@(posedge clock) disable iff (reset)
      found_index_ff <= token_count_ff)
      else $error("found index ahead of token count");

endmodule

// ===== verif/find_in_comma_set_check.sv =====
module find_in_comma_set_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic [1:0]  req_tuser,   // [0] operation, [1] is_null
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [15:0] position
   input  logic [1:0]  rsp_tuser,   // [0] null_result, [1] needle_overflow
   output int          mismatches,
   output int          outstanding
);

   logic [fics_pkg::BYTE_W-1:0] needle_bytes [fics_pkg::NEEDLE_MAX];
   logic [fics_pkg::LEN_W-1:0]  needle_len;
   logic [fics_pkg::LEN_W-1:0]  hit_len;
   logic [fics_pkg::POS_W-1:0]  tokens_seen;
   logic [fics_pkg::POS_W-1:0]  first_hit;
   logic                        needle_comma, needle_ended, needle_spilled;
   logic                        set_ended, row_null, token_alive, token_filled;
   fics_pkg::result_type        positions_due [$];

   function automatic void clear_token();
      hit_len      = '0;
      token_alive  = 1'b1;
      token_filled = 1'b0;
   endfunction

   function automatic void clear_row();
      needle_len     = '0;
      needle_comma   = 1'b0;
      needle_ended   = 1'b0;
      needle_spilled = 1'b0;
      set_ended      = 1'b0;
      row_null       = 1'b0;
      tokens_seen    = '0;
      first_hit      = '0;
      clear_token();
   endfunction

   function automatic void close_token();
      if (token_filled) begin
         if (tokens_seen != fics_pkg::TOKEN_MAX)
            tokens_seen++;
         if (token_alive && hit_len == needle_len && first_hit == '0)
            first_hit = tokens_seen;
      end
      clear_token();
   endfunction

   function automatic void needle_in(input logic [fics_pkg::BYTE_W-1:0] b);
      if (needle_ended)
         return;
      if (b == fics_pkg::NUL_BYTE) begin
         needle_ended = 1'b1;
         return;
      end
      if (b == fics_pkg::COMMA_BYTE)
         needle_comma = 1'b1;
      if (needle_len < fics_pkg::LEN_W'(fics_pkg::NEEDLE_MAX)) begin
         needle_bytes[needle_len[fics_pkg::NEEDLE_AW-1:0]] = b;
         needle_len++;
      end else begin
         needle_spilled = 1'b1;
      end
   endfunction

   function automatic void set_in(input logic [fics_pkg::BYTE_W-1:0] b);
      if (set_ended)
         return;
      if (b == fics_pkg::NUL_BYTE) begin
         set_ended = 1'b1;
         close_token();
         return;
      end
      if (b == fics_pkg::COMMA_BYTE) begin
         close_token();
         return;
      end
      token_filled = 1'b1;
      if (token_alive) begin
         if (hit_len < needle_len && needle_bytes[hit_len[fics_pkg::NEEDLE_AW-1:0]] == b)
            hit_len++;
         else
            token_alive = 1'b0;
      end
   endfunction

   function automatic void absorb(input logic op, input logic [fics_pkg::BYTE_W-1:0] b,
                                  input logic lst, input logic nul);
      fics_pkg::result_type want;
      if (nul)
         row_null = 1'b1;
      else if (op == fics_pkg::OP_NEEDLE)
         needle_in(b);
      else
         set_in(b);
      if (op == fics_pkg::OP_SET && lst) begin
         close_token();
         want = '0;
         if (row_null) begin
            want.null_result = 1'b1;
         end else begin
            want.needle_overflow = needle_spilled;
            if (!needle_comma && !needle_spilled)
               want.position = first_hit;
         end
         positions_due.push_back(want);
         clear_row();
      end
   endfunction

   always @(posedge clock) begin
      fics_pkg::result_type want;
      if (reset) begin
         clear_row();
         positions_due.delete();
      end else begin
         // results first, so a stray result never pairs with this edge's transaction
         if (rsp_tvalid && rsp_tready) begin
            if (positions_due.size() == 0) begin
               $display("%0t: unexpected result position %0d null %0b overflow %0b",
                        $time, rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
               mismatches++;
            end else begin
               want = positions_due.pop_front();
               if (rsp_tdata !== want.position) begin
                  $display("%0t: position expected %0d got %0d",
                           $time, want.position, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser[0] !== want.null_result) begin
                  $display("%0t: null_result expected %0b got %0b",
                           $time, want.null_result, rsp_tuser[0]);
                  mismatches++;
               end
               if (rsp_tuser[1] !== want.needle_overflow) begin
                  $display("%0t: needle_overflow expected %0b got %0b",
                           $time, want.needle_overflow, rsp_tuser[1]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb(req_tuser[0], req_tdata, req_tlast, req_tuser[1]);
      end
      outstanding = positions_due.size();
   end

endmodule

// ===== verif/find_in_comma_set_unit_test.sv =====
module find_in_comma_set_unit_test;

   typedef logic [fics_pkg::BYTE_W-1:0] byte_q_type [$];

   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 375;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int mismatches;
   int outstanding;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int items_sent = 0;
   int idle_plan [4] = '{0, 59, 0, 33};
   int stall_plan [4] = '{0, 0, 59, 33};

   find_in_comma_set_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   find_in_comma_set_check row_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #12_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_item(input logic op, input logic [7:0] b, input logic lst,
                            input logic nul);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {nul, op};
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_span(input logic op, input byte_q_type q, input int from,
                            input int upto, input int null_at, input bit ends);
      for (int i = from; i < upto; i++)
         send_item(op, q[i], ends && i == upto - 1, i == null_at);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (6) @(negedge clock);
   endtask

   function automatic byte_q_type text_bytes(input string s);
      byte_q_type q;
      for (int i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      if (q.size() == 0)
         q.push_back(fics_pkg::NUL_BYTE);
      return q;
   endfunction

   task automatic text_row(input string ntext, input string htext, input int null_side);
      byte_q_type nq, hq;
      nq = text_bytes(ntext);
      hq = text_bytes(htext);
      send_span(fics_pkg::OP_NEEDLE, nq, 0, nq.size(), (null_side == 1) ? 0 : -1, 1'b1);
      send_span(fics_pkg::OP_SET, hq, 0, hq.size(), (null_side == 2) ? 0 : -1, 1'b1);
   endtask

   function automatic logic [7:0] pick_byte(input bit for_needle);
      int r;
      r = $urandom_range(99);
      if (for_needle && r < 4)
         return fics_pkg::COMMA_BYTE;
      if (r < 88)
         return 8'h61 + 8'($urandom_range(2));
      return 8'($urandom_range(255));
   endfunction

   task automatic random_row();
      byte_q_type needle, hay, tok;
      int style, nlen, r, cut, null_n, null_h;
      style = $urandom_range(99);
      if (style < 10) begin
         repeat ($urandom_range(1, 12))
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                      $urandom_range(3) == 0, $urandom_range(15) == 0);
         return;
      end
      nlen = ($urandom_range(24) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 4);
      repeat (nlen)
         needle.push_back(pick_byte(1'b1));
      if ($urandom_range(29) == 0)
         needle.insert($urandom_range(needle.size()), fics_pkg::NUL_BYTE);
      if ($urandom_range(9) == 0)
         hay.push_back(fics_pkg::COMMA_BYTE);
      for (int t = $urandom_range(0, 6); t > 0; t--) begin
         r = $urandom_range(99);
         tok = needle;
         if (r >= 40 && r < 50) begin
            tok.delete();
         end else if (r >= 50 && r < 60) begin
            tok.push_back(pick_byte(1'b0));
         end else if (r >= 60 && r < 70) begin
            if (tok.size() > 0)
               void'(tok.pop_back());
         end else if (r >= 70) begin
            tok.delete();
            repeat ($urandom_range(1, 4))
               tok.push_back(pick_byte(1'b0));
         end
         hay = {hay, tok};
         if (t > 1 || $urandom_range(9) == 0)
            hay.push_back(fics_pkg::COMMA_BYTE);
      end
      if ($urandom_range(19) == 0)
         hay.insert($urandom_range(hay.size()), fics_pkg::NUL_BYTE);
      if (needle.size() == 0)
         needle.push_back(fics_pkg::NUL_BYTE);
      if (hay.size() == 0)
         hay.push_back(fics_pkg::NUL_BYTE);
      null_n = ($urandom_range(24) == 0) ? $urandom_range(needle.size() - 1) : -1;
      null_h = ($urandom_range(24) == 0) ? $urandom_range(hay.size() - 1) : -1;
      if (style < 20 && hay.size() > 1) begin
         // search bytes arrive after part of the set string
         cut = $urandom_range(1, hay.size() - 1);
         send_span(fics_pkg::OP_SET, hay, 0, cut, null_h, 1'b0);
         send_span(fics_pkg::OP_NEEDLE, needle, 0, needle.size(), null_n, 1'b1);
         send_span(fics_pkg::OP_SET, hay, cut, hay.size(), null_h, 1'b1);
      end else begin
         send_span(fics_pkg::OP_NEEDLE, needle, 0, needle.size(), null_n, 1'b1);
         send_span(fics_pkg::OP_SET, hay, 0, hay.size(), null_h, 1'b1);
      end
   endtask

   initial begin
      int budget;
      bit held;
      held = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      text_row("ab", "ab", 0);
      text_row("b", ",,a,,b,", 0);
      text_row("", "a", 0);
      text_row("a", "", 0);
      text_row("a,b", "a,b", 0);
      text_row("a", "a", 1);
      text_row("a", "a", 2);
      text_row("\377\200", "x,\377\200", 0);
      // NUL cuts the search string short
      send_item(fics_pkg::OP_NEEDLE, "a", 1'b0, 1'b0);
      send_item(fics_pkg::OP_NEEDLE, fics_pkg::NUL_BYTE, 1'b0, 1'b0);
      send_item(fics_pkg::OP_NEEDLE, "x", 1'b1, 1'b0);
      send_item(fics_pkg::OP_SET, "a", 1'b1, 1'b0);
      // NUL cuts the set string short
      send_item(fics_pkg::OP_NEEDLE, "a", 1'b1, 1'b0);
      send_item(fics_pkg::OP_SET, "b", 1'b0, 1'b0);
      send_item(fics_pkg::OP_SET, fics_pkg::NUL_BYTE, 1'b0, 1'b0);
      send_item(fics_pkg::OP_SET, fics_pkg::COMMA_BYTE, 1'b0, 1'b0);
      send_item(fics_pkg::OP_SET, "a", 1'b1, 1'b0);
      // search bytes appended after set bytes
      send_item(fics_pkg::OP_NEEDLE, "a", 1'b1, 1'b0);
      send_item(fics_pkg::OP_SET, "x", 1'b0, 1'b0);
      send_item(fics_pkg::OP_SET, fics_pkg::COMMA_BYTE, 1'b0, 1'b0);
      send_item(fics_pkg::OP_NEEDLE, "b", 1'b1, 1'b0);
      send_item(fics_pkg::OP_SET, "a", 1'b0, 1'b0);
      send_item(fics_pkg::OP_SET, "b", 1'b1, 1'b0);
      // needle store overflow
      repeat (fics_pkg::NEEDLE_MAX + 1)
         send_item(fics_pkg::OP_NEEDLE, "a", 1'b0, 1'b0);
      send_item(fics_pkg::OP_NEEDLE, "a", 1'b1, 1'b0);
      send_item(fics_pkg::OP_SET, "a", 1'b1, 1'b0);
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         budget = items_sent + PHASE_ITEMS;
         while (items_sent < budget) begin
            random_row();
            if (p == 0 && !held && items_sent > budget - 250) begin
               held = 1'b1;
               hold_trigger++;
               repeat (40)
                  text_row("a", "b,a", 0);
               drain();
            end
         end
         drain();
      end

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/fics_pkg.sv
hdl/fics_ram.sv
hdl/fics_scan.sv
hdl/find_in_comma_set_unit.sv
verif/find_in_comma_set_check.sv
verif/find_in_comma_set_unit_test.sv
